[sv/edt_pkg.sv]
// Shared constants and types for the event dependency tracker.
package edt_pkg;

  localparam int MAX_EVENTS  = 1024;
  localparam int TABLE_SLOTS = 4096;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int DEP_AW      = $clog2(MAX_EVENTS);
  localparam int CNT_W       = $clog2(MAX_EVENTS) + 1;
  localparam int VERT_W      = 31;
  localparam int IDX_W       = 10;
  localparam int PRED_W      = 11;
  localparam int EPOCH_W     = 8;

  localparam logic [63:0] HASH_K0 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_M1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_M2 = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VERT_W-1:0]  key;
    logic [IDX_W-1:0]   last_idx;
  } slot_entry_t;

endpackage

[sv/edt_hash.sv]
// Multi-cycle splitmix64 hash of a vertex id, reduced to a table slot.
module edt_hash
  import edt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VERT_W-1:0] vertex,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);

  typedef enum logic {H_IDLE, H_MUL} hstate_t;

  hstate_t           hstate_r;
  logic [1:0]        step_r;
  logic              round_r;
  logic [63:0]       a_r;
  logic [63:0]       acc_r;
  logic [63:0]       prod_r;
  logic              done_r;
  logic [SLOT_W-1:0] slot_r;

  logic [63:0] x_sum;
  logic [63:0] b_const;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] acc_sum;
  logic [63:0] z_fold;

  assign x_sum   = {33'b0, vertex} + HASH_K0;
  assign b_const = round_r ? HASH_M2 : HASH_M1;
  assign op_a    = (step_r == 2'd1) ? a_r[63:32] : a_r[31:0];
  assign op_b    = (step_r == 2'd2) ? b_const[63:32] : b_const[31:0];
  assign prod    = {32'b0, op_a} * {32'b0, op_b};
  // The first partial product lands unshifted; the two cross terms go to the upper half.
  assign acc_sum = (step_r == 2'd1) ? (acc_r + prod_r) : (acc_r + {prod_r[31:0], 32'b0});
  assign z_fold  = acc_sum ^ (acc_sum >> 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstate_r <= H_IDLE;
      done_r   <= 1'b0;
    end else begin
      done_r <= (hstate_r == H_MUL) && (step_r == 2'd3) && round_r;
      unique case (hstate_r)
        H_IDLE: begin
          if (start) begin
            a_r      <= x_sum ^ (x_sum >> 30);
            acc_r    <= '0;
            step_r   <= 2'd0;
            round_r  <= 1'b0;
            hstate_r <= H_MUL;
          end
        end
        H_MUL: begin
          prod_r <= prod;
          if ((step_r == 2'd3) && !round_r) begin
            a_r     <= acc_sum ^ (acc_sum >> 27);
            acc_r   <= '0;
            round_r <= 1'b1;
            step_r  <= 2'd0;
          end else begin
            step_r <= step_r + 2'd1;
            if (step_r != 2'd0) begin
              acc_r <= acc_sum;
            end
            if (step_r == 2'd3) begin
              slot_r   <= z_fold[SLOT_W-1:0];
              hstate_r <= H_IDLE;
            end
          end
        end
        default: hstate_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

[sv/event_dependency_tracker.sv]
// Event dependency tracker: each event beat gets an index, its predecessor and its chain depth.
//
// Input channel (in_*): one beat per edge event, a source and a destination vertex and a
// window_start flag that empties the vertex table and restarts the local index first.
// Output channel (out_*): exactly one result beat per input beat, in order: event index,
// predecessor (-1 for a root), chain depth and an overflow flag for events past the window.
// Both channels move a beat when valid is high and stall is low.
//
// One event at a time. An event is taken, its count is checked, two hash passes run on the
// shared 32x32 multiplier, and the table probes run with a read and a check per slot
// visited: two lookups, a read of the depth memory, two stores, linear probing in the slot
// memory. Then the result is issued. An event past the window skips the hashing, probing
// and depth memory.
// in_stall is high while an event is being worked on.
//
// After reset the slot memory is swept once, one slot a cycle, before the first beat is
// taken. Window starts mark slots stale by an epoch number; every 255th window start
// repeats the same sweep. A finished result waits in the output register while out_stall
// is high, and the next beat is already taken meanwhile.
module event_dependency_tracker
  import edt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_window_start,
  input  logic [VERT_W-1:0]        in_src_vertex,
  input  logic [VERT_W-1:0]        in_dst_vertex,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_event_index,
  output logic signed [PRED_W-1:0] out_predecessor,
  output logic [IDX_W-1:0]         out_chain_depth,
  output logic                     out_overflow
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_HASH_U, S_HASH_V,
    S_PROBE_RD, S_PROBE_CHK, S_DEPTH_RD, S_DEPTH_WAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {OP_LOOK_U, OP_LOOK_V, OP_STORE_U, OP_STORE_V} op_t;

  state_t              state_r;
  op_t                 op_r;
  logic [VERT_W-1:0]   u_r;
  logic [VERT_W-1:0]   v_r;
  logic [CNT_W-1:0]    count_r;
  logic [EPOCH_W-1:0]  epoch_r;
  logic [SLOT_W-1:0]   clr_addr_r;
  logic                resume_r;
  logic [SLOT_W-1:0]   home_u_r;
  logic [SLOT_W-1:0]   home_v_r;
  logic [SLOT_W-1:0]   paddr_r;
  logic [SLOT_W-1:0]   pn_r;
  logic                pu_vld_r;
  logic [IDX_W-1:0]    pu_r;
  logic                pv_vld_r;
  logic [IDX_W-1:0]    pv_r;
  logic                p_vld_r;
  logic [IDX_W-1:0]    p_r;
  logic [IDX_W-1:0]    depth_r;
  logic                ovf_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [PRED_W-1:0]   out_pred_r;
  logic [IDX_W-1:0]    out_depth_r;
  logic                out_ovf_r;

  slot_entry_t         slot_mem [TABLE_SLOTS];
  slot_entry_t         slot_rd_r;
  logic [IDX_W-1:0]    dep_mem [MAX_EVENTS];
  logic [IDX_W-1:0]    dep_rd_r;

  logic                slot_we;
  logic [SLOT_W-1:0]   slot_waddr;
  slot_entry_t         slot_wdata;
  logic                slot_re;
  logic                dep_we;
  logic                dep_re;
  logic [IDX_W-1:0]    dep_wdata;

  logic [VERT_W-1:0]   key;
  logic                is_store;
  logic                hit_valid;
  logic                hit_match;
  logic                last_probe;
  logic                probe_end;
  logic [IDX_W-1:0]    p_sel;
  logic                out_ok;
  logic                full;

  logic                hash_start;
  logic [VERT_W-1:0]   hash_vertex;
  logic                hash_done;
  logic [SLOT_W-1:0]   hash_slot;

  edt_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .vertex (hash_vertex),
    .done   (hash_done),
    .slot   (hash_slot)
  );

  assign full        = (count_r == CNT_W'(MAX_EVENTS));
  assign hash_start  = ((state_r == S_CHECK) && !full) || ((state_r == S_HASH_U) && hash_done);
  assign hash_vertex = (state_r == S_CHECK) ? u_r : v_r;

  assign key        = ((op_r == OP_LOOK_U) || (op_r == OP_STORE_U)) ? u_r : v_r;
  assign is_store   = (op_r == OP_STORE_U) || (op_r == OP_STORE_V);
  // A slot counts as occupied only when it was written in the current window.
  assign hit_valid  = (slot_rd_r.epoch == epoch_r);
  assign hit_match  = hit_valid && (slot_rd_r.key == key);
  assign last_probe = (pn_r == SLOT_W'(TABLE_SLOTS - 1));
  assign probe_end  = !hit_valid || hit_match || last_probe;

  assign p_sel  = (pu_vld_r && (!pv_vld_r || (pu_r > pv_r))) ? pu_r : pv_r;
  assign out_ok = !out_valid_r || !out_stall;

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = paddr_r;
    slot_wdata = '{epoch: epoch_r, key: key, last_idx: count_r[IDX_W-1:0]};
    if (state_r == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_addr_r;
      slot_wdata = '0;
    end else if ((state_r == S_PROBE_CHK) && is_store && (!hit_valid || hit_match)) begin
      slot_we = 1'b1;
    end
  end

  assign slot_re   = (state_r == S_PROBE_RD);
  assign dep_re    = (state_r == S_DEPTH_RD);
  assign dep_we    = (state_r == S_DEPTH_WAIT);
  assign dep_wdata = p_vld_r ? (dep_rd_r + IDX_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[paddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[DEP_AW'(count_r)] <= dep_wdata;
    end
    if (dep_re) begin
      dep_rd_r <= dep_mem[DEP_AW'(p_sel)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      resume_r    <= 1'b0;
      epoch_r     <= EPOCH_W'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + SLOT_W'(1);
          if (clr_addr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
            state_r <= resume_r ? S_CHECK : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            u_r <= in_src_vertex;
            v_r <= in_dst_vertex;
            if (in_window_start) begin
              count_r <= '0;
            end
            // When the epoch number runs out, stale slots are wiped for real.
            if (in_window_start && (epoch_r == '1)) begin
              epoch_r    <= EPOCH_W'(1);
              clr_addr_r <= '0;
              resume_r   <= 1'b1;
              state_r    <= S_CLEAR;
            end else begin
              if (in_window_start) begin
                epoch_r <= epoch_r + EPOCH_W'(1);
              end
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          ovf_r   <= full;
          state_r <= full ? S_OUT : S_HASH_U;
        end
        S_HASH_U: begin
          if (hash_done) begin
            home_u_r <= hash_slot;
            state_r  <= S_HASH_V;
          end
        end
        S_HASH_V: begin
          if (hash_done) begin
            home_v_r <= hash_slot;
            op_r     <= OP_LOOK_U;
            paddr_r  <= home_u_r;
            pn_r     <= '0;
            state_r  <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: begin
          state_r <= S_PROBE_CHK;
        end
        S_PROBE_CHK: begin
          if (probe_end) begin
            pn_r <= '0;
            unique case (op_r)
              OP_LOOK_U: begin
                pu_vld_r <= hit_match;
                pu_r     <= slot_rd_r.last_idx;
                op_r     <= OP_LOOK_V;
                paddr_r  <= home_v_r;
                state_r  <= S_PROBE_RD;
              end
              OP_LOOK_V: begin
                pv_vld_r <= hit_match;
                pv_r     <= slot_rd_r.last_idx;
                state_r  <= S_DEPTH_RD;
              end
              OP_STORE_U: begin
                op_r    <= OP_STORE_V;
                paddr_r <= home_v_r;
                state_r <= S_PROBE_RD;
              end
              OP_STORE_V: begin
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end else begin
            paddr_r <= paddr_r + SLOT_W'(1);
            pn_r    <= pn_r + SLOT_W'(1);
            state_r <= S_PROBE_RD;
          end
        end
        S_DEPTH_RD: begin
          p_vld_r <= pu_vld_r || pv_vld_r;
          p_r     <= p_sel;
          state_r <= S_DEPTH_WAIT;
        end
        S_DEPTH_WAIT: begin
          depth_r <= dep_wdata;
          op_r    <= OP_STORE_U;
          paddr_r <= home_u_r;
          pn_r    <= '0;
          state_r <= S_PROBE_RD;
        end
        S_OUT: begin
          if (out_ok) begin
            out_ovf_r <= ovf_r;
            if (ovf_r) begin
              out_idx_r   <= '0;
              out_pred_r  <= '0;
              out_depth_r <= '0;
            end else begin
              out_idx_r   <= count_r[IDX_W-1:0];
              out_pred_r  <= p_vld_r ? {1'b0, p_r} : '1;
              out_depth_r <= depth_r;
              count_r     <= count_r + CNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_event_index = out_idx_r;
  assign out_predecessor = out_pred_r;
  assign out_chain_depth = out_depth_r;
  assign out_overflow    = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_EVENTS))
    else $error("event count beyond window size");

  a_pred_before: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ovf_r && (out_pred_r != '1)) |-> (out_pred_r[IDX_W-1:0] < out_idx_r))
    else $error("predecessor not older than event");

  a_root_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ovf_r) |-> ((out_pred_r == '1) == (out_depth_r == '0)))
    else $error("depth inconsistent with predecessor");

  a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> ((state_r == S_HASH_U) || (state_r == S_HASH_V)))
    else $error("hash finished outside a hash wait");
`endif

endmodule
